/* hdl/csq_pkg.sv */
`timescale 1ns / 1ps
package csq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF    = 8;
	localparam int PRIO_WIDTH_DEF  = 8;

	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 16;
	localparam int OP_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_TAKE    = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNAVAIL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ORDER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_PUT,
		S_HEAD
	} state_t;

endpackage

/* hdl/csq_ram.sv */
`timescale 1ns / 1ps
module csq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/counting_semaphore_wait_queue_top.sv */
`timescale 1ns / 1ps
// take, release without waiters, timeout on an empty queue: done in the cycle after accept
// release with waiters: via S_HEAD (one head read from the queue ram), then done is registered
// priority take and timeout: S_SCAN for each entry scanned, S_SHIFT for each entry shifted,
// S_PUT to place a priority insert inside the queue, then done; next accept in done cycle
// arst_n clears state, count, queue length, head pointer; queue ram is not cleared
// done is a one-cycle strobe, the receiver cannot stall it
module counting_semaphore_wait_queue_top #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = csq_pkg::ID_WIDTH_DEF,
	parameter int PRIO_WIDTH  = csq_pkg::PRIO_WIDTH_DEF,
	localparam int LW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [csq_pkg::OP_W-1:0]       op,
	input  logic [ID_WIDTH-1:0]            thread_id,
	input  logic [PRIO_WIDTH-1:0]          priority_req,
	input  logic                           wait_allowed,
	output logic                           done,
	output logic [csq_pkg::STATUS_W-1:0]   status,
	output logic                           woken_valid,
	output logic [ID_WIDTH-1:0]            woken_thread,
	output logic [csq_pkg::COUNT_W-1:0]    count_now,
	output logic [LW-1:0]                  waiters_now,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [csq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csq_pkg::COUNT_W-1:0]    cfg_data
);
	import csq_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int DW = ID_WIDTH + PRIO_WIDTH;
	localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);
	localparam logic [LW-1:0] ONE_L = LW'(1);

	state_t state_q, state_d;

	logic                  order_q;
	logic [COUNT_W-1:0]    max_q, count_q, count_d;
	logic [LW-1:0]         len_q, len_d, j_q, j_d, k_q, k_d;
	logic [PW-1:0]         head_q, head_d;
	logic [OP_W-1:0]       op_q;
	logic [ID_WIDTH-1:0]   id_q;
	logic [PRIO_WIDTH-1:0] prio_q;

	logic                  fin, fin_wv;
	logic [STATUS_W-1:0]   fin_st;
	logic                  done_q, wv_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ID_WIDTH-1:0]   wid_q;
	logic [COUNT_W-1:0]    cnt_out_q;
	logic [LW-1:0]         len_out_q;

	logic                  mem_we;
	logic [LW-1:0]         widx, ridx;
	logic [DW-1:0]         wdata, rdata;
	logic [ID_WIDTH-1:0]   rd_id;
	logic [PRIO_WIDTH-1:0] rd_prio;

	logic acc, need_scan, need_head, take_q, hit, scan_last, sh_end;

	function automatic logic [PW-1:0] phys(input logic [PW-1:0] head, input logic [LW-1:0] idx);
		logic [LW:0] s;
		s = (LW+1)'(head) + {1'b0, idx};
		if (s >= (LW+1)'(QUEUE_DEPTH)) begin
			s = s - (LW+1)'(QUEUE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	csq_ram #(.DEPTH(QUEUE_DEPTH), .AW(PW), .DW(DW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (phys(head_q, widx)),
		.wdata (wdata),
		.raddr (phys(head_q, ridx)),
		.rdata (rdata)
	);

	assign rd_id   = rdata[DW-1 -: ID_WIDTH];
	assign rd_prio = rdata[PRIO_WIDTH-1:0];

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign acc       = start && (state_q == S_IDLE);
	assign take_q    = (op_q == OP_TAKE);
	assign hit       = take_q ? (rd_prio < prio_q) : (rd_id == id_q);
	assign scan_last = ((j_q + ONE_L) == len_q);
	assign sh_end    = take_q ? (k_q == j_q) : ((k_q + ONE_L) == len_q);

	// priority insert into a nonempty queue, or timeout search
	assign need_scan = acc && (((op == OP_TAKE) && (count_q == '0) && wait_allowed
		&& (len_q != DEPTH_L) && order_q && (len_q != '0))
		|| ((op == OP_TIMEOUT) && (len_q != '0)));
	assign need_head = acc && (op == OP_RELEASE) && (len_q != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (need_scan) begin
					state_d = S_SCAN;
				end else if (need_head) begin
					state_d = S_HEAD;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = (!take_q && scan_last) ? S_IDLE : S_SHIFT;
				end else if (scan_last) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (sh_end) begin
					state_d = take_q ? S_PUT : S_IDLE;
				end
			end
			S_PUT:   state_d = S_IDLE;
			S_HEAD:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		count_d = count_q;
		len_d   = len_q;
		head_d  = head_q;
		j_d     = j_q;
		k_d     = k_q;
		fin     = 1'b0;
		fin_st  = ST_REMOVED;
		fin_wv  = 1'b0;
		mem_we  = 1'b0;
		widx    = len_q;
		wdata   = {thread_id, priority_req};
		ridx    = '0;
		case (state_q)
			S_IDLE: begin
				j_d = '0;
				if (acc) begin
					case (op)
						OP_TAKE: begin
							if (count_q != '0) begin
								count_d = count_q - 1'b1;
								fin     = 1'b1;
								fin_st  = ST_GRANTED;
							end else if (!wait_allowed) begin
								fin    = 1'b1;
								fin_st = ST_UNAVAIL;
							end else if (len_q == DEPTH_L) begin
								fin    = 1'b1;
								fin_st = ST_FULL;
							end else if (!order_q || (len_q == '0)) begin
								mem_we = 1'b1;
								len_d  = len_q + ONE_L;
								fin    = 1'b1;
								fin_st = ST_QUEUED;
							end
						end
						OP_RELEASE: begin
							if (len_q == '0) begin
								fin = 1'b1;
								if (count_q < max_q) begin
									count_d = count_q + 1'b1;
									fin_st  = ST_RELEASED;
								end else begin
									fin_st = ST_OVERFLOW;
								end
							end
						end
						OP_TIMEOUT: begin
							fin = (len_q == '0);
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				wdata = {id_q, prio_q};
				ridx  = scan_last ? '0 : j_q + ONE_L;
				if (hit) begin
					if (take_q) begin
						k_d  = len_q - ONE_L;
						ridx = len_q - ONE_L;
					end else if (scan_last) begin
						len_d = len_q - ONE_L;
						fin   = 1'b1;
					end else begin
						k_d = j_q + ONE_L;
					end
				end else if (scan_last) begin
					fin = 1'b1;
					if (take_q) begin
						mem_we = 1'b1;
						len_d  = len_q + ONE_L;
						fin_st = ST_QUEUED;
					end
				end else begin
					j_d = j_q + ONE_L;
				end
			end
			S_SHIFT: begin
				mem_we = 1'b1;
				wdata  = rdata;
				if (take_q) begin
					widx = k_q + ONE_L;
					ridx = sh_end ? '0 : k_q - ONE_L;
					k_d  = k_q - ONE_L;
				end else begin
					widx = k_q - ONE_L;
					ridx = sh_end ? '0 : k_q + ONE_L;
					k_d  = k_q + ONE_L;
					if (sh_end) begin
						len_d = len_q - ONE_L;
						fin   = 1'b1;
					end
				end
			end
			S_PUT: begin
				mem_we = 1'b1;
				widx   = j_q;
				wdata  = {id_q, prio_q};
				len_d  = len_q + ONE_L;
				fin    = 1'b1;
				fin_st = ST_QUEUED;
			end
			S_HEAD: begin
				head_d = phys(head_q, ONE_L);
				len_d  = len_q - ONE_L;
				fin    = 1'b1;
				fin_st = ST_RELEASED;
				fin_wv = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			order_q <= 1'b0;
			max_q   <= '1;
			count_q <= '0;
			len_q   <= '0;
			head_q  <= '0;
			done_q  <= 1'b0;
			wv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			head_q  <= head_d;
			done_q  <= fin;
			if (fin) begin
				wv_q <= fin_wv;
			end
			if (cfg_valid && cfg_ready && (cfg_index == CFG_INITIAL_COUNT)) begin
				count_q <= cfg_data;
			end else begin
				count_q <= count_d;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_QUEUE_ORDER:   order_q <= cfg_data[0];
					CFG_MAX_COUNT:     max_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		j_q <= j_d;
		k_q <= k_d;
		if (acc) begin
			op_q   <= op;
			id_q   <= thread_id;
			prio_q <= priority_req;
		end
		if (fin) begin
			status_q  <= fin_st;
			wid_q     <= fin_wv ? rd_id : '0;
			cnt_out_q <= count_d;
			len_out_q <= len_d;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign woken_valid  = done_q && wv_q;
	assign woken_thread = wid_q;
	assign count_now    = cnt_out_q;
	assign waiters_now  = len_out_q;
endmodule

/* hdl/csq_checker.sv */
`timescale 1ns / 1ps
module csq_checker #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = csq_pkg::ID_WIDTH_DEF,
	localparam int LW = $clog2(QUEUE_DEPTH + 1)
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [csq_pkg::STATUS_W-1:0] status,
	input logic                         woken_valid,
	input logic [ID_WIDTH-1:0]          woken_thread,
	input logic [LW-1:0]                waiters_now
);
	import csq_pkg::*;

	// a woken thread only comes with a release word
	a_woken_release: assert property (@(posedge clk) disable iff (!arst_n)
		woken_valid |-> done && (status == ST_RELEASED))
		else $error("woken without release");

	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !woken_valid) |-> (woken_thread == '0))
		else $error("woken id not zero");

	a_queued_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_QUEUED)) |-> (waiters_now != '0))
		else $error("queued with empty queue");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (waiters_now <= LW'(QUEUE_DEPTH)))
		else $error("waiters above depth");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without start");
endmodule

bind counting_semaphore_wait_queue_top csq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.ID_WIDTH    (ID_WIDTH)
) u_csq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.woken_valid  (woken_valid),
	.woken_thread (woken_thread),
	.waiters_now  (waiters_now)
);
